FILE: hdl/palette_color_dedupe_macros.svh
// assertion macros for the palette color dedupe block
`ifndef PALETTE_COLOR_DEDUPE_MACROS_SVH
`define PALETTE_COLOR_DEDUPE_MACROS_SVH

`ifndef ASSERT_OFF
`define PCD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcd check failed");
`define PCD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcd check failed");
`else
`define PCD_ASSERT_IMP(label, ante, cons)
`define PCD_ASSERT_NXT(label, ante, cons)
`endif

`endif

FILE: hdl/pcd_pkg.sv
// shared types and constants for the palette color dedupe block
package pcd_pkg;

    localparam int CAPACITY_DEFAULT = 256;
    localparam int COLOR_W          = 24;
    localparam int SLOT_W           = 8;
    localparam int COUNT_W          = 9;

    typedef enum logic [1:0] {
        PCD_IDLE,
        PCD_SCAN,
        PCD_MISS,
        PCD_EMIT
    } pcd_state_t;

    typedef struct packed {
        logic [COLOR_W-1:0] color_out;
        logic               is_new;
        logic [SLOT_W-1:0]  slot;
        logic               table_full;
        logic [COUNT_W-1:0] distinct_count;
        logic               last_out;
    } pcd_result_t;

endpackage

FILE: hdl/pcd_in_if.sv
// input channel carrying palette colors
interface pcd_in_if;
    logic        valid;
    logic        ready;
    logic [23:0] color;
    logic        last_color;

    modport source (output valid, output color, output last_color, input ready);
    modport sink (input valid, input color, input last_color, output ready);
endinterface

FILE: hdl/pcd_out_if.sv
// output channel carrying per-color dedupe results
interface pcd_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] color_out;
    logic        is_new;
    logic [7:0]  slot;
    logic        table_full;
    logic [8:0]  distinct_count;
    logic        last_out;

    modport source (output valid, output color_out, output is_new, output slot,
                    output table_full, output distinct_count, output last_out,
                    input ready);
    modport sink (input valid, input color_out, input is_new, input slot,
                  input table_full, input distinct_count, input last_out,
                  output ready);
endinterface

FILE: hdl/pcd_mem.sv
// color table memory, one write port and one registered read port
module pcd_mem #(
    parameter int CAPACITY = pcd_pkg::CAPACITY_DEFAULT,
    parameter int AW       = $clog2(CAPACITY)
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [AW-1:0]            waddr,
    input  logic [pcd_pkg::COLOR_W-1:0] wdata,
    input  logic [AW-1:0]            raddr,
    output logic [pcd_pkg::COLOR_W-1:0] rdata
);
    import pcd_pkg::*;

    logic [COLOR_W-1:0] mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/pcd_ctrl.sv
// scan sequencer: searches, appends misses until full, keeps the count
module pcd_ctrl #(
    parameter int CAPACITY = pcd_pkg::CAPACITY_DEFAULT,
    parameter int AW       = $clog2(CAPACITY),
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [pcd_pkg::COLOR_W-1:0] in_color,
    input  logic                        in_last,
    output logic                        res_valid,
    input  logic                        res_ready,
    output pcd_pkg::pcd_result_t        res,
    output logic                        mem_we,
    output logic [AW-1:0]               mem_waddr,
    output logic [pcd_pkg::COLOR_W-1:0] mem_wdata,
    output logic [AW-1:0]               mem_raddr,
    input  logic [pcd_pkg::COLOR_W-1:0] mem_rdata
);
    import pcd_pkg::*;

    localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

    pcd_state_t         state_reg, state_next;
    logic [COLOR_W-1:0] color_reg, color_next;
    logic               last_reg, last_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      count_reg, count_next;
    pcd_result_t        res_reg, res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PCD_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        color_reg <= color_next;
        last_reg  <= last_next;
        idx_reg   <= idx_next;
        res_reg   <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        color_next = color_reg;
        last_next  = last_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        res_next   = res_reg;
        in_ready   = 1'b0;
        res_valid  = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = AW'(count_reg);
        mem_wdata  = color_reg;
        mem_raddr  = AW'(idx_reg + 1'b1);

        unique case (state_reg)
            PCD_IDLE:
            begin
                in_ready  = 1'b1;
                mem_raddr = '0;
                if (in_valid)
                begin
                    color_next = in_color;
                    last_next  = in_last;
                    idx_next   = '0;
                    state_next = (count_reg == '0) ? PCD_MISS : PCD_SCAN;
                end
            end
            PCD_SCAN:
            begin
                if (mem_rdata == color_reg)
                begin
                    res_next.color_out      = color_reg;
                    res_next.is_new         = 1'b0;
                    res_next.slot           = SLOT_W'(idx_reg);
                    res_next.table_full     = 1'b0;
                    res_next.distinct_count = COUNT_W'(count_reg);
                    res_next.last_out       = last_reg;
                    state_next              = PCD_EMIT;
                end
                else if (CW'(idx_reg) + 1'b1 == count_reg)
                begin
                    state_next = PCD_MISS;
                end
                else
                begin
                    idx_next = AW'(idx_reg + 1'b1);
                end
            end
            PCD_MISS:
            begin
                res_next.color_out = color_reg;
                res_next.last_out  = last_reg;
                if (count_reg < CAP_COUNT)
                begin
                    mem_we                  = 1'b1;
                    res_next.is_new         = 1'b1;
                    res_next.slot           = SLOT_W'(count_reg);
                    res_next.table_full     = 1'b0;
                    res_next.distinct_count = COUNT_W'(CW'(count_reg + 1'b1));
                    count_next              = CW'(count_reg + 1'b1);
                end
                else
                begin
                    res_next.is_new         = 1'b0;
                    res_next.slot           = '0;
                    res_next.table_full     = 1'b1;
                    res_next.distinct_count = COUNT_W'(count_reg);
                end
                state_next = PCD_EMIT;
            end
            PCD_EMIT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    if (last_reg)
                    begin
                        count_next = '0;
                    end
                    state_next = PCD_IDLE;
                end
            end
            default:
            begin
                state_next = PCD_IDLE;
            end
        endcase
    end

    assign res = res_reg;

endmodule

FILE: hdl/palette_color_dedupe.sv
// top level: palette color dedupe with table memory and output register
//
//  channel   dir   payload                                               handshake
//  palette   in    color, last_color                                     valid/ready
//  result    out   color_out, is_new, slot, table_full, distinct_count,  valid/ready
//                  last_out
//
// a color is searched with one table read per stored entry (up to CAPACITY entries),
// all through the single memory read port
// reset empties the table at once; no clearing pass is needed
// a finished result waits in the output register while the next color is taken
// a stalled result channel holds the sequencer only once its result is ready

`include "palette_color_dedupe_macros.svh"

module palette_color_dedupe #(
    parameter int CAPACITY = pcd_pkg::CAPACITY_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    pcd_in_if.sink    palette,
    pcd_out_if.source result
);
    import pcd_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic               res_valid;
    logic               res_ready;
    pcd_result_t        res;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [COLOR_W-1:0] mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [COLOR_W-1:0] mem_rdata;

    logic               out_valid_reg, out_valid_next;
    pcd_result_t        out_reg, out_next;

    logic               full_ok;

    pcd_mem #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    pcd_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (palette.valid),
        .in_ready  (palette.ready),
        .in_color  (palette.color),
        .in_last   (palette.last_color),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    assign res_ready = !out_valid_reg || result.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result.valid          = out_valid_reg;
    assign result.color_out      = out_reg.color_out;
    assign result.is_new         = out_reg.is_new;
    assign result.slot           = out_reg.slot;
    assign result.table_full     = out_reg.table_full;
    assign result.distinct_count = out_reg.distinct_count;
    assign result.last_out       = out_reg.last_out;

    // a dropped color leaves the count at capacity and is never marked new
    assign full_ok = (result.distinct_count == COUNT_W'(CAPACITY)) && !result.is_new;

    `PCD_ASSERT_NXT(a_one_in_flight, palette.valid && palette.ready, !palette.ready)
    `PCD_ASSERT_NXT(a_result_loaded, res_valid && res_ready, result.valid)
    `PCD_ASSERT_IMP(a_full_count, result.valid && result.table_full, full_ok)

endmodule
